/* rtl/core/radial_tangential_distortion_map_defines.svh */
// assertion macros used by the checker module
`ifndef RADIAL_TANGENTIAL_DISTORTION_MAP_DEFINES_SVH
`define RADIAL_TANGENTIAL_DISTORTION_MAP_DEFINES_SVH

// clocked property, quiet while reset is high
`define RTDM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked during reset too
`define RTDM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/rtdm_pkg.sv */
package rtdm_pkg;

  // fixed point layout of the internal datapath
  localparam int FRAC_BITS  = 28;
  localparam int NORM_SHIFT = 12;

  typedef logic signed [47:0] wide_t;
  typedef logic signed [48:0] mul_op_t;
  typedef logic signed [49:0] sum_t;

  localparam wide_t WIDE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam sum_t  SUM_MAX  = 50'sh0_7FFF_FFFF_FFFF;
  localparam wide_t ONE_Q28  = 48'sh0000_1000_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_K_RADIAL_1     = 3'd0,
    CFG_K_RADIAL_2     = 3'd1,
    CFG_P_TANGENTIAL_1 = 3'd2,
    CFG_P_TANGENTIAL_2 = 3'd3,
    CFG_SOURCE_FOCAL_X = 3'd4,
    CFG_SOURCE_FOCAL_Y = 3'd5,
    CFG_SOURCE_CENTRE_X = 3'd6,
    CFG_SOURCE_CENTRE_Y = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] point_u;
    logic signed [31:0] point_v;
    logic signed [31:0] target_centre_u;
    logic signed [31:0] target_centre_v;
    logic [31:0]        target_inv_focal_u;
    logic [31:0]        target_inv_focal_v;
    logic               last_point;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] distorted_u;
    logic signed [31:0] distorted_v;
    logic               saturated;
    logic               last_out;
  } out_beat_t;

  // multiplier control: pipeline advance and rounding position
  typedef struct packed {
    logic en;
    logic norm;
  } mul_ctl_t;

  typedef struct packed {
    wide_t value;
    logic  sat;
  } wide_res_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } out_res_t;

  function automatic sum_t w50(input wide_t v);
    return {{2{v[47]}}, v};
  endfunction

  function automatic mul_op_t to_op(input wide_t v);
    return {v[47], v};
  endfunction

  function automatic wide_res_t clamp_wide(input sum_t v);
    wide_res_t r;
    r.sat = 1'b1;
    if (v > SUM_MAX) begin
      r.value = WIDE_MAX;
    end else if (v < -SUM_MAX) begin
      r.value = -WIDE_MAX;
    end else begin
      r.value = v[47:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  function automatic out_res_t to_out32(input logic signed [48:0] v);
    out_res_t r;
    r.sat = 1'b1;
    if (v > 49'sh0_7FFF_FFFF) begin
      r.value = 32'h7FFF_FFFF;
    end else if (v < -49'sh0_8000_0000) begin
      r.value = 32'h8000_0000;
    end else begin
      r.value = v[31:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/core/rtdm_mul_round.sv */
module rtdm_mul_round (
  input  logic                 clk,
  input  rtdm_pkg::mul_ctl_t   ctl,
  input  rtdm_pkg::mul_op_t    a,
  input  rtdm_pkg::mul_op_t    b,
  output rtdm_pkg::wide_res_t  res
);

  localparam logic [95:0] NORM_HALF = 96'(1) << (rtdm_pkg::NORM_SHIFT - 1);
  localparam logic [95:0] FRAC_HALF = 96'(1) << (rtdm_pkg::FRAC_BITS - 1);

  rtdm_pkg::mul_op_t a_abs;
  rtdm_pkg::mul_op_t b_abs;
  logic              s1_neg;
  logic [47:0]       s1_ma;
  logic [47:0]       s1_mb;
  logic              s2_neg;
  logic [63:0]       s2_p00;
  logic [47:0]       s2_p01;
  logic [47:0]       s2_p10;
  logic [31:0]       s2_p11;
  logic              s3_neg;
  logic [95:0]       s3_full;
  logic [95:0]       shifted;
  logic              over;
  rtdm_pkg::wide_t   mag;

  // stage 1: sign and magnitudes
  assign a_abs = a[48] ? -a : a;
  assign b_abs = b[48] ? -b : b;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s1_neg <= a[48] ^ b[48];
      s1_ma  <= a_abs[47:0];
      s1_mb  <= b_abs[47:0];
    end
  end

  // stage 2: partial products, none wider than 32 x 32
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s2_neg <= s1_neg;
      s2_p00 <= 64'(s1_ma[31:0]) * 64'(s1_mb[31:0]);
      s2_p01 <= 48'(s1_ma[31:0]) * 48'(s1_mb[47:32]);
      s2_p10 <= 48'(s1_ma[47:32]) * 48'(s1_mb[31:0]);
      s2_p11 <= 32'(s1_ma[47:32]) * 32'(s1_mb[47:32]);
    end
  end

  // stage 3: full product plus rounding half
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s3_neg  <= s2_neg;
      s3_full <= 96'(s2_p00) + (96'(s2_p01) << 32) + (96'(s2_p10) << 32)
               + (96'(s2_p11) << 64) + (ctl.norm ? NORM_HALF : FRAC_HALF);
    end
  end

  // stage 4: drop fraction, clip magnitude, restore sign
  always_comb begin
    shifted = ctl.norm ? (s3_full >> rtdm_pkg::NORM_SHIFT)
                       : (s3_full >> rtdm_pkg::FRAC_BITS);
    over    = |shifted[95:47];
    mag     = over ? rtdm_pkg::WIDE_MAX : {1'b0, shifted[46:0]};
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      res.value <= s3_neg ? -mag : mag;
      res.sat   <= over;
    end
  end

endmodule

/* rtl/core/radial_tangential_distortion_map.sv */
// Brown-Conrady k1 k2 p1 p2 distortion map: every input beat carries one
// undistorted Q16.16 point with its target centre and reciprocal focal
// lengths, and yields one beat with the saturated distorted source point.
// One beat is accepted per clock unless the output is stalled; latency comes
// from the chain of six four-stage 48 x 48 rounding multipliers (normalise,
// squares, r^4, k2 term, distortion products, source intrinsics) plus the add
// stages. A skid register at the input catches one beat while the output is
// stalled. Configuration writes take effect at once and belong to idle time.
module radial_tangential_distortion_map (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rtdm_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rtdm_pkg::out_beat_t  out_data,
  input  logic                 cfg_we,
  input  rtdm_pkg::cfg_reg_e   cfg_index,
  input  logic [31:0]          cfg_data
);

  // stage where each group of values sits in its registers
  localparam int ST_XY   = 5;
  localparam int ST_SQ   = 9;
  localparam int ST_R2   = 10;
  localparam int ST_T    = 11;
  localparam int ST_R4   = 14;
  localparam int ST_K2   = 18;
  localparam int ST_RAD  = 19;
  localparam int ST_PROD = 23;
  localparam int ST_F    = 28;
  localparam int LAT     = 29;

  localparam int XY_DEPTH  = ST_RAD - ST_XY;
  localparam int TXY_DEPTH = ST_RAD - ST_R2;
  localparam int T_DEPTH   = ST_RAD - ST_T;
  localparam int K1_DEPTH  = ST_K2 - ST_R4;

  logic signed [31:0] k_radial_1;
  logic signed [31:0] k_radial_2;
  logic signed [31:0] p_tangential_1;
  logic signed [31:0] p_tangential_2;
  logic [31:0]        source_focal_x;
  logic [31:0]        source_focal_y;
  logic signed [31:0] source_centre_x;
  logic signed [31:0] source_centre_y;

  logic                en;
  logic                skid_full;
  rtdm_pkg::in_beat_t  skid;
  rtdm_pkg::in_beat_t  pipe_in;
  logic                pipe_vld;
  logic [LAT:1]        vld;

  logic signed [32:0]  du_q;
  logic signed [32:0]  dv_q;
  logic [31:0]         ifu_q;
  logic [31:0]         ifv_q;

  rtdm_pkg::mul_ctl_t  norm_ctl;
  rtdm_pkg::mul_ctl_t  frac_ctl;

  rtdm_pkg::wide_res_t x_r, y_r, x2_r, y2_r, xy_r, r4_r, k1r2_r, k2r4_r;
  rtdm_pkg::wide_res_t xr_r, yr_r, p1xy_r, p2tx_r, p1ty_r, p2xy_r, fx_r, fy_r;

  rtdm_pkg::wide_t     r2_q, x2_q, y2_q, txy_q, tx_q, ty_q, rad_q, xd_q, yd_q;
  rtdm_pkg::wide_t     x_line   [XY_DEPTH];
  rtdm_pkg::wide_t     y_line   [XY_DEPTH];
  rtdm_pkg::wide_t     txy_line [TXY_DEPTH];
  rtdm_pkg::wide_t     tx_line  [T_DEPTH];
  rtdm_pkg::wide_t     ty_line  [T_DEPTH];
  rtdm_pkg::wide_t     k1_line  [K1_DEPTH];

  rtdm_pkg::wide_res_t r2_c, txy_c, tx_c, ty_c, rad_c, xd_c, yd_c;
  rtdm_pkg::out_res_t  ou_c, ov_c;
  logic [LAT-1:1]      extra;
  logic                sat_line  [1:LAT-1];
  logic                last_line [1:LAT-1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k_radial_1      <= '0;
      k_radial_2      <= '0;
      p_tangential_1  <= '0;
      p_tangential_2  <= '0;
      source_focal_x  <= 32'h0001_0000;
      source_focal_y  <= 32'h0001_0000;
      source_centre_x <= '0;
      source_centre_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rtdm_pkg::CFG_K_RADIAL_1:      k_radial_1      <= cfg_data;
        rtdm_pkg::CFG_K_RADIAL_2:      k_radial_2      <= cfg_data;
        rtdm_pkg::CFG_P_TANGENTIAL_1:  p_tangential_1  <= cfg_data;
        rtdm_pkg::CFG_P_TANGENTIAL_2:  p_tangential_2  <= cfg_data;
        rtdm_pkg::CFG_SOURCE_FOCAL_X:  source_focal_x  <= cfg_data;
        rtdm_pkg::CFG_SOURCE_FOCAL_Y:  source_focal_y  <= cfg_data;
        rtdm_pkg::CFG_SOURCE_CENTRE_X: source_centre_x <= cfg_data;
        rtdm_pkg::CFG_SOURCE_CENTRE_Y: source_centre_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output register is free or drained
  assign en        = !out_valid || out_ready;
  assign in_ready  = !skid_full;
  assign out_valid = vld[LAT];
  assign pipe_in   = skid_full ? skid : in_data;
  assign pipe_vld  = skid_full || in_valid;
  assign norm_ctl  = '{en: en, norm: 1'b1};
  assign frac_ctl  = '{en: en, norm: 1'b0};

  // input skid register catches one beat during an output stall
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (en) begin
      skid_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_valid && in_ready) begin
      skid <= in_data;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], pipe_vld};
    end
  end

  // stage 1: offsets from the target centre
  always_ff @(posedge clk) begin
    if (en) begin
      du_q  <= {pipe_in.point_u[31], pipe_in.point_u}
             - {pipe_in.target_centre_u[31], pipe_in.target_centre_u};
      dv_q  <= {pipe_in.point_v[31], pipe_in.point_v}
             - {pipe_in.target_centre_v[31], pipe_in.target_centre_v};
      ifu_q <= pipe_in.target_inv_focal_u;
      ifv_q <= pipe_in.target_inv_focal_v;
    end
  end

  // normalised coordinates
  rtdm_mul_round u_mul_x (
    .clk(clk), .ctl(norm_ctl),
    .a({{16{du_q[32]}}, du_q}), .b({17'b0, ifu_q}), .res(x_r)
  );
  rtdm_mul_round u_mul_y (
    .clk(clk), .ctl(norm_ctl),
    .a({{16{dv_q[32]}}, dv_q}), .b({17'b0, ifv_q}), .res(y_r)
  );

  // squares and cross term
  rtdm_mul_round u_mul_x2 (
    .clk(clk), .ctl(frac_ctl),
    .a(rtdm_pkg::to_op(x_r.value)), .b(rtdm_pkg::to_op(x_r.value)), .res(x2_r)
  );
  rtdm_mul_round u_mul_y2 (
    .clk(clk), .ctl(frac_ctl),
    .a(rtdm_pkg::to_op(y_r.value)), .b(rtdm_pkg::to_op(y_r.value)), .res(y2_r)
  );
  rtdm_mul_round u_mul_xy (
    .clk(clk), .ctl(frac_ctl),
    .a(rtdm_pkg::to_op(x_r.value)), .b(rtdm_pkg::to_op(y_r.value)), .res(xy_r)
  );

  // r^4 and k1 term
  rtdm_mul_round u_mul_r4 (
    .clk(clk), .ctl(frac_ctl),
    .a(rtdm_pkg::to_op(r2_q)), .b(rtdm_pkg::to_op(r2_q)), .res(r4_r)
  );
  rtdm_mul_round u_mul_k1 (
    .clk(clk), .ctl(frac_ctl),
    .a({{17{k_radial_1[31]}}, k_radial_1}), .b(rtdm_pkg::to_op(r2_q)), .res(k1r2_r)
  );

  // k2 term
  rtdm_mul_round u_mul_k2 (
    .clk(clk), .ctl(frac_ctl),
    .a({{17{k_radial_2[31]}}, k_radial_2}), .b(rtdm_pkg::to_op(r4_r.value)),
    .res(k2r4_r)
  );

  // radial and tangential products
  rtdm_mul_round u_mul_xr (
    .clk(clk), .ctl(frac_ctl),
    .a(rtdm_pkg::to_op(x_line[XY_DEPTH-1])), .b(rtdm_pkg::to_op(rad_q)), .res(xr_r)
  );
  rtdm_mul_round u_mul_yr (
    .clk(clk), .ctl(frac_ctl),
    .a(rtdm_pkg::to_op(y_line[XY_DEPTH-1])), .b(rtdm_pkg::to_op(rad_q)), .res(yr_r)
  );
  rtdm_mul_round u_mul_p1xy (
    .clk(clk), .ctl(frac_ctl),
    .a({{17{p_tangential_1[31]}}, p_tangential_1}),
    .b(rtdm_pkg::to_op(txy_line[TXY_DEPTH-1])), .res(p1xy_r)
  );
  rtdm_mul_round u_mul_p2tx (
    .clk(clk), .ctl(frac_ctl),
    .a({{17{p_tangential_2[31]}}, p_tangential_2}),
    .b(rtdm_pkg::to_op(tx_line[T_DEPTH-1])), .res(p2tx_r)
  );
  rtdm_mul_round u_mul_p1ty (
    .clk(clk), .ctl(frac_ctl),
    .a({{17{p_tangential_1[31]}}, p_tangential_1}),
    .b(rtdm_pkg::to_op(ty_line[T_DEPTH-1])), .res(p1ty_r)
  );
  rtdm_mul_round u_mul_p2xy (
    .clk(clk), .ctl(frac_ctl),
    .a({{17{p_tangential_2[31]}}, p_tangential_2}),
    .b(rtdm_pkg::to_op(txy_line[TXY_DEPTH-1])), .res(p2xy_r)
  );

  // source focal lengths
  rtdm_mul_round u_mul_fx (
    .clk(clk), .ctl(frac_ctl),
    .a({17'b0, source_focal_x}), .b(rtdm_pkg::to_op(xd_q)), .res(fx_r)
  );
  rtdm_mul_round u_mul_fy (
    .clk(clk), .ctl(frac_ctl),
    .a({17'b0, source_focal_y}), .b(rtdm_pkg::to_op(yd_q)), .res(fy_r)
  );

  // saturating sums between the multiplier stages
  always_comb begin
    r2_c  = rtdm_pkg::clamp_wide(rtdm_pkg::w50(x2_r.value) + rtdm_pkg::w50(y2_r.value));
    txy_c = rtdm_pkg::clamp_wide(rtdm_pkg::w50(xy_r.value) + rtdm_pkg::w50(xy_r.value));
    tx_c  = rtdm_pkg::clamp_wide(rtdm_pkg::w50(r2_q) + rtdm_pkg::w50(x2_q)
                                 + rtdm_pkg::w50(x2_q));
    ty_c  = rtdm_pkg::clamp_wide(rtdm_pkg::w50(r2_q) + rtdm_pkg::w50(y2_q)
                                 + rtdm_pkg::w50(y2_q));
    rad_c = rtdm_pkg::clamp_wide(rtdm_pkg::w50(rtdm_pkg::ONE_Q28)
                                 + rtdm_pkg::w50(k1_line[K1_DEPTH-1])
                                 + rtdm_pkg::w50(k2r4_r.value));
    xd_c  = rtdm_pkg::clamp_wide(rtdm_pkg::w50(xr_r.value) + rtdm_pkg::w50(p1xy_r.value)
                                 + rtdm_pkg::w50(p2tx_r.value));
    yd_c  = rtdm_pkg::clamp_wide(rtdm_pkg::w50(yr_r.value) + rtdm_pkg::w50(p1ty_r.value)
                                 + rtdm_pkg::w50(p2xy_r.value));
    ou_c  = rtdm_pkg::to_out32({fx_r.value[47], fx_r.value}
                               + {{17{source_centre_x[31]}}, source_centre_x});
    ov_c  = rtdm_pkg::to_out32({fy_r.value[47], fy_r.value}
                               + {{17{source_centre_y[31]}}, source_centre_y});
  end

  // clip events seen at each stage
  always_comb begin
    extra          = '0;
    extra[ST_XY]   = x_r.sat | y_r.sat;
    extra[ST_SQ]   = x2_r.sat | y2_r.sat | xy_r.sat | r2_c.sat | txy_c.sat;
    extra[ST_R2]   = tx_c.sat | ty_c.sat;
    extra[ST_R4]   = r4_r.sat | k1r2_r.sat;
    extra[ST_K2]   = k2r4_r.sat | rad_c.sat;
    extra[ST_PROD] = xr_r.sat | yr_r.sat | p1xy_r.sat | p2tx_r.sat | p1ty_r.sat
                   | p2xy_r.sat | xd_c.sat | yd_c.sat;
    extra[ST_F]    = fx_r.sat | fy_r.sat | ou_c.sat | ov_c.sat;
  end

  // stage registers of the add steps
  always_ff @(posedge clk) begin
    if (en) begin
      r2_q  <= r2_c.value;
      txy_q <= txy_c.value;
      x2_q  <= x2_r.value;
      y2_q  <= y2_r.value;
      tx_q  <= tx_c.value;
      ty_q  <= ty_c.value;
      rad_q <= rad_c.value;
      xd_q  <= xd_c.value;
      yd_q  <= yd_c.value;
    end
  end

  // delay lines that line operands up with the radial factor and the k2 term
  always_ff @(posedge clk) begin
    if (en) begin
      x_line[0]   <= x_r.value;
      y_line[0]   <= y_r.value;
      txy_line[0] <= txy_q;
      tx_line[0]  <= tx_q;
      ty_line[0]  <= ty_q;
      k1_line[0]  <= k1r2_r.value;
      for (int i = 1; i < XY_DEPTH; i++) begin
        x_line[i] <= x_line[i-1];
        y_line[i] <= y_line[i-1];
      end
      for (int i = 1; i < TXY_DEPTH; i++) begin
        txy_line[i] <= txy_line[i-1];
      end
      for (int i = 1; i < T_DEPTH; i++) begin
        tx_line[i] <= tx_line[i-1];
        ty_line[i] <= ty_line[i-1];
      end
      for (int i = 1; i < K1_DEPTH; i++) begin
        k1_line[i] <= k1_line[i-1];
      end
    end
  end

  // clip flag and batch mark ride along with each beat
  always_ff @(posedge clk) begin
    if (en) begin
      sat_line[1]  <= 1'b0;
      last_line[1] <= pipe_in.last_point;
      for (int k = 2; k < LAT; k++) begin
        sat_line[k]  <= sat_line[k-1] | extra[k-1];
        last_line[k] <= last_line[k-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.distorted_u <= ou_c.value;
      out_data.distorted_v <= ov_c.value;
      out_data.saturated   <= sat_line[LAT-1] | extra[LAT-1];
      out_data.last_out    <= last_line[LAT-1];
    end
  end

endmodule

/* rtl/core/rtdm_port_check.sv */
`include "radial_tangential_distortion_map_defines.svh"

module rtdm_port_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rtdm_pkg::out_beat_t out_data
);

  // reset leaves the block empty and open for a beat
  `RTDM_ASSERT_ALWAYS(a_reset_empty, clk, !rst && $past(rst) |-> !out_valid && in_ready, "not empty after reset")

  // a stalled result beat holds
  `RTDM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // a beat taken during an output stall fills the skid and closes the input
  `RTDM_ASSERT(a_skid_fill, clk, rst, in_valid && in_ready && out_valid && !out_ready |=> !in_ready, "skid not closed")

  // the skid drains as soon as the pipeline moves
  `RTDM_ASSERT(a_skid_drain, clk, rst, !in_ready && (!out_valid || out_ready) |=> in_ready, "skid did not drain")

endmodule

bind radial_tangential_distortion_map rtdm_port_check u_port_check (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);
